>>> sv/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = 6;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0] HDR_LEN   = CNT_W'(6);
    localparam logic [CNT_W-1:0] FRAME_MAX = CNT_W'(MAX_PAYLOAD + 6);
    localparam logic [CNT_W-1:0] POS_LEN   = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_CMD   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CRC   = CNT_W'(4);

    localparam logic [7:0]  START_RST = 8'hAA;
    localparam logic [7:0]  END_RST   = 8'h55;
    localparam logic [7:0]  HB_RST    = 8'h00;
    localparam logic [15:0] POLY_RST  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HB    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POLY  = CFG_IDX_W'(3);

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_START   = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_BAD_END    = 3'd3,
        ST_BAD_CRC    = 3'd4,
        ST_OVERFLOW   = 3'd5
    } frame_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_STATUS,
        S_PAYLOAD
    } fpd_state_t;

    typedef struct packed {
        logic keep;
        logic check;
        logic load_payload;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_last;
    } dp_status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/fpd_ram.sv
// ----------------------------------------------------------------------------
// fpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fpd_ctrl.sv
// ----------------------------------------------------------------------------
// fpd_ctrl
// Sequencer: takes bytes, runs the frame check, then hands out the items.
// ----------------------------------------------------------------------------
module fpd_ctrl
    import fpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last_byte,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  dp_cmd
);

    fpd_state_t state_reg, state_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && s_last_byte) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_STATUS;
            end
            S_STATUS, S_PAYLOAD: begin
                if (out_acc) begin
                    state_next = dp_stat.out_last ? S_IDLE : S_PAYLOAD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready             = 1'b0;
        m_valid             = 1'b0;
        dp_cmd.keep         = 1'b0;
        dp_cmd.check        = 1'b0;
        dp_cmd.load_payload = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                dp_cmd.keep = s_valid;
            end
            S_CHECK: begin
                dp_cmd.check = 1'b1;
            end
            S_STATUS, S_PAYLOAD: begin
                m_valid             = 1'b1;
                dp_cmd.load_payload = m_ready && !dp_stat.out_last;
            end
            default: begin
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while an item is pending");

    a_last_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_last_byte) |=> (state_reg == S_CHECK))
        else $error("final byte did not start the check");

    a_check_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |=> (m_valid && !s_ready))
        else $error("status item not presented after check");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && dp_stat.out_last) |=> s_ready)
        else $error("block not free after final item");

endmodule

>>> sv/fpd_datapath.sv
// ----------------------------------------------------------------------------
// fpd_datapath
// Frame state, CRC update, payload store, frame check and output register.
// ----------------------------------------------------------------------------
module fpd_datapath
    import fpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             dp_cmd,
    output dp_status_t            dp_stat,
    input  logic [7:0]            s_data_byte,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_item_kind,
    output logic [2:0]            m_status,
    output logic [7:0]            m_command,
    output logic [LEN_W-1:0]      m_payload_length,
    output logic [7:0]            m_payload_byte,
    output logic                  m_last_result
);

    logic [7:0]  start_reg, start_next;
    logic [7:0]  end_reg, end_next;
    logic [7:0]  hb_reg, hb_next;
    logic [15:0] poly_reg, poly_next;

    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       dl_reg [3];
    logic [7:0]       dl_next [3];
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             ovf_reg, ovf_next;

    logic             kind_reg, kind_next;
    frame_status_t    stat_reg, stat_next;
    logic [7:0]       ocmd_reg, ocmd_next;
    logic [LEN_W-1:0] olen_reg, olen_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;
    logic [LEN_W-1:0] idx_reg, idx_next;

    logic          start_now;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    frame_status_t chk;

    assign start_now = seen_reg || (s_data_byte == start_reg);
    assign ram_we    = dp_cmd.keep && start_now && (count_reg < FRAME_MAX)
                       && (count_reg >= HDR_LEN);

    fpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (PAY_AW'(count_reg - HDR_LEN)),
        .wdata (dl_reg[2]),
        .raddr (idx_next[PAY_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (!seen_reg) begin
            chk = ST_NO_START;
        end else if (ovf_reg) begin
            chk = ST_OVERFLOW;
        end else if (count_reg < HDR_LEN) begin
            chk = ST_INCOMPLETE;
        end else if ((count_reg == HDR_LEN) && (cmd_reg != hb_reg)) begin
            chk = ST_INCOMPLETE;
        end else if (8'(count_reg - HDR_LEN) != len_reg) begin
            chk = ST_INCOMPLETE;
        end else if (dl_reg[0] != end_reg) begin
            chk = ST_BAD_END;
        end else if ({dl_reg[2], dl_reg[1]} != crc_reg) begin
            chk = ST_BAD_CRC;
        end else begin
            chk = ST_OK;
        end
    end

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        hb_next    = hb_reg;
        poly_next  = poly_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        dl_next    = dl_reg;
        crc_next   = crc_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        ovf_next   = ovf_reg;
        kind_next  = kind_reg;
        stat_next  = stat_reg;
        ocmd_next  = ocmd_reg;
        olen_next  = olen_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        idx_next   = idx_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_START: start_next = cfg_data[7:0];
                CFG_END:   end_next   = cfg_data[7:0];
                CFG_HB:    hb_next    = cfg_data[7:0];
                CFG_POLY:  poly_next  = cfg_data;
                default: begin
                end
            endcase
        end

        if (dp_cmd.keep && start_now) begin
            seen_next = 1'b1;
            if (count_reg >= FRAME_MAX) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg == POS_LEN) begin
                    len_next = s_data_byte;
                end
                if (count_reg == POS_CMD) begin
                    cmd_next = s_data_byte;
                end
                if (count_reg >= POS_CRC) begin
                    crc_next = crc_feed(crc_reg, dl_reg[2], poly_reg);
                end
                if (count_reg != '0) begin
                    dl_next[2] = dl_reg[1];
                    dl_next[1] = dl_reg[0];
                    dl_next[0] = s_data_byte;
                end
            end
        end

        if (dp_cmd.check) begin
            kind_next  = KIND_STATUS;
            stat_next  = chk;
            obyte_next = '0;
            idx_next   = '0;
            if (chk == ST_OK) begin
                ocmd_next  = cmd_reg;
                olen_next  = len_reg[LEN_W-1:0];
                olast_next = (len_reg == 8'd0);
            end else begin
                ocmd_next  = '0;
                olen_next  = '0;
                olast_next = 1'b1;
            end
            seen_next  = 1'b0;
            count_next = '0;
            dl_next    = '{default: 8'h00};
            crc_next   = CRC_INIT;
            len_next   = '0;
            cmd_next   = '0;
            ovf_next   = 1'b0;
        end

        if (dp_cmd.load_payload) begin
            kind_next  = KIND_PAYLOAD;
            stat_next  = ST_OK;
            obyte_next = ram_rdata;
            olast_next = ((idx_reg + LEN_W'(1)) == olen_reg);
            idx_next   = idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_RST;
            end_reg   <= END_RST;
            hb_reg    <= HB_RST;
            poly_reg  <= POLY_RST;
            seen_reg  <= 1'b0;
            count_reg <= '0;
            dl_reg    <= '{default: 8'h00};
            crc_reg   <= CRC_INIT;
            len_reg   <= '0;
            cmd_reg   <= '0;
            ovf_reg   <= 1'b0;
            olast_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
            hb_reg    <= hb_next;
            poly_reg  <= poly_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            dl_reg    <= dl_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            ovf_reg   <= ovf_next;
            olast_reg <= olast_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        stat_reg  <= stat_next;
        ocmd_reg  <= ocmd_next;
        olen_reg  <= olen_next;
        obyte_reg <= obyte_next;
    end

    assign dp_stat.out_last  = olast_reg;
    assign m_item_kind       = kind_reg;
    assign m_status          = stat_reg;
    assign m_command         = ocmd_reg;
    assign m_payload_length  = olen_reg;
    assign m_payload_byte    = obyte_reg;
    assign m_last_result     = olast_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FRAME_MAX)
        else $error("byte count beyond frame limit");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == FRAME_MAX) && seen_reg)
        else $error("overflow without full frame");

    a_check_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.check |=> !seen_reg && (count_reg == '0) && (crc_reg == CRC_INIT))
        else $error("frame state not cleared after check");

endmodule

>>> sv/framed_packet_deframer_crc16.sv
// ----------------------------------------------------------------------------
// framed_packet_deframer_crc16
// Byte-stream frame deframer with reflected CRC-16 check and payload output.
// ----------------------------------------------------------------------------
// Non-final bytes: one item per cycle, no result.
// Final byte: the frame check runs in S_CHECK, then the status item shows on
// m_ valid; payload items follow, read from the payload RAM, one per cycle
// while m_ready is high. Input is held off until the last result item is taken.
// Reset: synchronous, active low; frame state, settings, last flag and index
// return to defaults; output item fields and payload RAM are not cleared.
// ----------------------------------------------------------------------------
module framed_packet_deframer_crc16
    import fpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_item_kind,
    output logic [2:0]            m_status,
    output logic [7:0]            m_command,
    output logic [LEN_W-1:0]      m_payload_length,
    output logic [7:0]            m_payload_byte,
    output logic                  m_last_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_stat;

    assign cfg_ready = 1'b1;

    fpd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .dp_stat     (dp_stat),
        .dp_cmd      (dp_cmd)
    );

    fpd_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dp_cmd           (dp_cmd),
        .dp_stat          (dp_stat),
        .s_data_byte      (s_data_byte),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_item_kind      (m_item_kind),
        .m_status         (m_status),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_result    (m_last_result)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CRC-16 frame deframer. A cycle-level model of
// the frame state predicts every status and payload item from the accepted
// bytes. The stimulus is a few hand-built frames followed by random frames,
// good and damaged, under several register settings. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
module testbench;
    import fpd_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FRAME_BYTES    = MAX_PAYLOAD + 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(255);

    typedef struct {
        logic             item_kind;
        frame_status_t    status;
        logic [7:0]       command;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             last_result;
    } result_t;

    class frame_tracker;
        result_t     results_due[$];
        int unsigned errors;
        int unsigned frames;
        int unsigned results_matched;
        int unsigned payload_items;
        int unsigned status_seen[6];

        logic [7:0]  start_val;
        logic [7:0]  end_val;
        logic [7:0]  hb_cmd;
        logic [15:0] poly;

        bit          in_frame;
        bit          overflowed;
        int unsigned kept;
        logic [7:0]  recent[3];
        logic [15:0] crc;
        logic [7:0]  len_byte;
        logic [7:0]  cmd_byte;
        logic [7:0]  payload[MAX_PAYLOAD];

        function new();
            start_val = START_RST;
            end_val   = END_RST;
            hb_cmd    = HB_RST;
            poly      = POLY_RST;
            foreach (payload[i]) payload[i] = 8'h00;
            clear_frame();
        endfunction

        static function logic [15:0] crc16_step(logic [15:0] c_in, logic [7:0] b,
                                                logic [15:0] p);
            logic [15:0] c;
            c = c_in ^ {8'h00, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
            return c;
        endfunction

        function void clear_frame();
            in_frame   = 1'b0;
            overflowed = 1'b0;
            kept       = 0;
            recent     = '{default: 8'h00};
            crc        = CRC_INIT;
            len_byte   = 8'h00;
            cmd_byte   = 8'h00;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_START: start_val = val[7:0];
                CFG_END:   end_val   = val[7:0];
                CFG_HB:    hb_cmd    = val[7:0];
                CFG_POLY:  poly      = val[15:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned   pos;
            int unsigned   n;
            frame_status_t st;
            result_t       r;
            if (!in_frame && b == start_val) in_frame = 1'b1;
            if (in_frame) begin
                if (kept >= FRAME_BYTES) begin
                    overflowed = 1'b1;
                end else begin
                    pos = kept;
                    kept++;
                    if (pos == 1) len_byte = b;
                    if (pos == 2) cmd_byte = b;
                    if (pos != 0) begin
                        // CRC and payload run three bytes behind the input
                        if (pos >= 4) crc = crc16_step(crc, recent[2], poly);
                        if (pos >= 6) payload[pos - 6] = recent[2];
                        recent[2] = recent[1];
                        recent[1] = recent[0];
                        recent[0] = b;
                    end
                end
            end
            if (!last) return;

            if (!in_frame)                              st = ST_NO_START;
            else if (overflowed)                        st = ST_OVERFLOW;
            else if (kept < 6)                          st = ST_INCOMPLETE;
            else if (kept == 6 && cmd_byte != hb_cmd)   st = ST_INCOMPLETE;
            else if (kept - 6 != len_byte)              st = ST_INCOMPLETE;
            else if (recent[0] != end_val)              st = ST_BAD_END;
            else if ({recent[2], recent[1]} != crc)     st = ST_BAD_CRC;
            else                                        st = ST_OK;

            n = (st == ST_OK) ? len_byte : 0;
            r.item_kind      = KIND_STATUS;
            r.status         = st;
            r.command        = (st == ST_OK) ? cmd_byte : 8'h00;
            r.payload_length = LEN_W'(n);
            r.payload_byte   = 8'h00;
            r.last_result    = (n == 0);
            results_due.push_back(r);
            for (int i = 0; i < n; i++) begin
                r.item_kind    = KIND_PAYLOAD;
                r.status       = ST_OK;
                r.payload_byte = payload[i];
                r.last_result  = (i + 1 == n);
                results_due.push_back(r);
            end
            status_seen[st]++;
            frames++;
            clear_frame();
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                         $time, field, results_matched, want, got);
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got kind %0d status %0d",
                         $time, got.item_kind, got.status);
                return;
            end
            want = results_due.pop_front();
            compare("item_kind", want.item_kind, got.item_kind);
            compare("status", want.status, got.status);
            compare("command", want.command, got.command);
            compare("payload_length", want.payload_length, got.payload_length);
            compare("payload_byte", want.payload_byte, got.payload_byte);
            compare("last_result", want.last_result, got.last_result);
            if (want.item_kind == KIND_PAYLOAD) payload_items++;
            results_matched++;
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic [7:0]            s_data_byte = 8'h00;
    logic                  s_last_byte = 1'b0;
    logic                  m_ready     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_item_kind;
    logic [2:0]            m_status;
    logic [7:0]            m_command;
    logic [LEN_W-1:0]      m_payload_length;
    logic [7:0]            m_payload_byte;
    logic                  m_last_result;
    logic                  cfg_ready;

    frame_tracker sb;
    logic [7:0]   frame_bytes[$];
    logic [7:0]   payload_bytes[$];
    int unsigned  bytes_taken   = 0;
    int unsigned  settings_used = 1;
    int unsigned  hold_cycles   = 0;
    bit           steady_phase  = 1'b0;

    framed_packet_deframer_crc16 uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item_kind      (m_item_kind),
        .m_status         (m_status),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_result    (m_last_result),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // All tasks are entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!steady_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_byte(b, last);
        bytes_taken++;
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Byte registers get junk in the upper half of the data
    task automatic set_config(input logic [7:0] start_v, input logic [7:0] end_v,
                              input logic [7:0] hb_v, input logic [15:0] poly_v);
        write_reg(CFG_START, {8'($urandom), start_v});
        write_reg(CFG_END, {8'($urandom), end_v});
        write_reg(CFG_HB, {8'($urandom), hb_v});
        write_reg(CFG_POLY, poly_v);
        settings_used++;
    endtask

    function automatic void add_junk(input int unsigned count);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom);
            if (b == sb.start_val) b = ~b;
            frame_bytes.push_back(b);
        end
    endfunction

    function automatic void put_frame(input logic [7:0] cmd);
        logic [15:0] c;
        logic [7:0]  len;
        len = 8'(payload_bytes.size());
        c = frame_tracker::crc16_step(CRC_INIT, len, sb.poly);
        c = frame_tracker::crc16_step(c, cmd, sb.poly);
        frame_bytes.push_back(sb.start_val);
        frame_bytes.push_back(len);
        frame_bytes.push_back(cmd);
        foreach (payload_bytes[i]) begin
            frame_bytes.push_back(payload_bytes[i]);
            c = frame_tracker::crc16_step(c, payload_bytes[i], sb.poly);
        end
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(sb.end_val);
    endfunction

    function automatic void make_random_frame();
        int unsigned pick;
        int unsigned plen;
        int unsigned k;
        logic [7:0]  cmd;
        frame_bytes.delete();
        payload_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            add_junk($urandom_range(1, 6));
            return;
        end
        if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
        cmd  = 8'($urandom);
        plen = 0;
        if (pick < 14) begin
            cmd = sb.hb_cmd;
        end else if (pick < 20) begin
            cmd = sb.hb_cmd ^ 8'($urandom_range(1, 255));
        end else if (pick >= 95) begin
            plen = MAX_PAYLOAD;
        end else if ($urandom_range(0, 11) == 0) begin
            plen = $urandom_range(17, MAX_PAYLOAD);
        end else begin
            plen = $urandom_range(1, 8);
        end
        repeat (plen) payload_bytes.push_back(8'($urandom));
        put_frame(cmd);
        k = frame_bytes.size();
        if (pick >= 65 && pick < 72) begin
            frame_bytes[k - 1] ^= 8'($urandom_range(1, 255));
        end else if (pick >= 72 && pick < 79) begin
            frame_bytes[k - 3 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick >= 79 && pick < 85) begin
            frame_bytes[k - plen - 5] ^= 8'($urandom_range(1, 255));
        end else if (pick >= 85 && pick < 95) begin
            repeat ($urandom_range(1, k - 1)) void'(frame_bytes.pop_back());
        end else if (pick >= 95) begin
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        end
    endfunction

    initial begin : result_sink
        int unsigned n;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_cycles != 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                m_ready <= 1'b0;
            end else if (!steady_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 12);
                m_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 16);
                m_ready <= 1'b1;
            end
            repeat (n) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.item_kind      = m_item_kind;
            got.status         = frame_status_t'(m_status);
            got.command        = m_command;
            got.payload_length = m_payload_length;
            got.payload_byte   = m_payload_byte;
            got.last_result    = m_last_result;
            sb.match_result(got);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("%0t: run timed out with %0d results still due", $time,
                 sb.results_due.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_end[4];
        phase_end = '{105, 190, 285, 370};
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // hand-built frames at reset settings
        frame_bytes = {8'h00};
        send_frame();
        frame_bytes = {8'hFF};
        payload_bytes.delete();
        put_frame(sb.hb_cmd);
        send_frame();
        frame_bytes.delete();
        payload_bytes = {8'hFF};
        put_frame(START_RST);
        frame_bytes[$] = 8'h00;
        send_frame();
        frame_bytes.delete();
        payload_bytes = {START_RST};
        put_frame(8'h01);
        frame_bytes[$ - 1] ^= 8'h01;
        send_frame();
        frame_bytes = {START_RST, 8'h02};
        send_frame();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_config(8'h00, 8'hFF, 8'hFF, 16'hFFFF);
                    write_reg(CFG_SPARE, 16'($urandom));
                end
                1: set_config(8'hFF, 8'h00, 8'h00, 16'h0000);
                2: set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
                default: set_config(START_RST, END_RST, HB_RST, POLY_RST);
            endcase
            if (phase == 1) hold_cycles = 150;
            if (phase == 3) steady_phase = 1'b1;
            while (bytes_taken < phase_end[phase]) begin
                make_random_frame();
                send_frame();
                if (!steady_phase && $urandom_range(0, 19) == 0) drain();
            end
            drain();
        end

        $display("Checked %0d frames (%0d bytes, %0d register settings), %0d items matched",
                 sb.frames, bytes_taken, settings_used, sb.results_matched);
        $display({"Status mix: ok %0d, no start %0d, incomplete %0d, bad end %0d, ",
                  "bad crc %0d, overflow %0d; payload items %0d"},
                 sb.status_seen[ST_OK], sb.status_seen[ST_NO_START],
                 sb.status_seen[ST_INCOMPLETE], sb.status_seen[ST_BAD_END],
                 sb.status_seen[ST_BAD_CRC], sb.status_seen[ST_OVERFLOW], sb.payload_items);
        if (sb.errors == 0 && sb.results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/fpd_pkg.sv
sv/fpd_ram.sv
sv/fpd_ctrl.sv
sv/fpd_datapath.sv
sv/framed_packet_deframer_crc16.sv
tb/testbench.sv
